[src/hrhp_pkg.sv]
// shared codes, constants and result type for the http request header parser
package hrhp_pkg;

	// input function codes
	localparam logic [1:0] FN_DATA  = 2'd0;
	localparam logic [1:0] FN_OPEN  = 2'd1;
	localparam logic [1:0] FN_CLOSE = 2'd2;

	// result status codes
	localparam logic [3:0] ST_STORED   = 4'd0;
	localparam logic [3:0] ST_CONSUMED = 4'd1;
	localparam logic [3:0] ST_COMPLETE = 4'd2;
	localparam logic [3:0] ST_SYNTAX   = 4'd3;
	localparam logic [3:0] ST_LONG     = 4'd4;
	localparam logic [3:0] ST_URI      = 4'd5;
	localparam logic [3:0] ST_IDLE     = 4'd6;
	localparam logic [3:0] ST_PAST     = 4'd7;
	localparam logic [3:0] ST_STARTED  = 4'd8;
	localparam logic [3:0] ST_REFUSED  = 4'd9;
	localparam logic [3:0] ST_RELEASED = 4'd10;

	// http response codes
	localparam logic [8:0] RC_NONE        = 9'd0;
	localparam logic [8:0] RC_BAD_REQUEST = 9'd400;
	localparam logic [8:0] RC_URI_LONG    = 9'd414;
	localparam logic [8:0] RC_HDR_LARGE   = 9'd431;

	// destination codes
	localparam logic [1:0] DST_NONE   = 2'd0;
	localparam logic [1:0] DST_METHOD = 2'd1;
	localparam logic [1:0] DST_URL    = 2'd2;
	localparam logic [1:0] DST_HEADER = 2'd3;

	// characters of interest
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5a;
	localparam logic [7:0] CH_CR      = 8'h0d;
	localparam logic [7:0] CH_LF      = 8'h0a;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// one result word
	typedef struct packed {
		logic [3:0] status;
		logic [8:0] response_code;
		logic [1:0] dest;
		logic [9:0] dest_index;
		logic [7:0] byte_out;
	} result_t;

endpackage

[src/hrhp_if.sv]
// request byte and result word channel interfaces
interface hrhp_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] byte_in;

	modport source (output valid, output func, output byte_in, input ready);
	modport sink (input valid, input func, input byte_in, output ready);
endinterface

interface hrhp_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] status;
	logic [8:0] response_code;
	logic [1:0] dest;
	logic [9:0] dest_index;
	logic [7:0] byte_out;

	modport source (output valid, output status, output response_code, output dest,
		output dest_index, output byte_out, input ready);
	modport sink (input valid, input status, input response_code, input dest,
		input dest_index, input byte_out, output ready);
endinterface

[src/http_request_header_parser.sv]
// top level of the http request header parser: input stage and result handshake
//
// Usage:
//   rx carries one word per handshake: func (0 data byte, 1 open, 2 close) and
//   byte_in. tx returns exactly one result word for each rx word, in order:
//   status, response_code, dest, dest_index and byte_out.
//   A word accepted on rx is held in the input stage and evaluated by the
//   parse state machine when the result register is free; its result is
//   written to the result register, and from there it drives tx.
//   Throughput is one word per cycle while tx takes its words: the phase
//   update for a byte is a single transition of the parse state machine, so
//   nothing iterates.
//   When tx is stalled the result register holds its word, the input stage
//   keeps one more word and rx.ready drops until tx takes its word.
//   Reset clears both stages; the parser starts with no request open, so data
//   bytes report idle until an open word arrives.
module http_request_header_parser #(
	parameter int METHOD_MAX = 10,
	parameter int URL_MAX    = 64,
	parameter int HEADER_MAX = 512
) (
	input logic         clk,
	input logic         arst_n,
	hrhp_in_if.sink     rx,
	hrhp_out_if.source  tx
);
	import hrhp_pkg::*;

	logic       valid_s1;
	logic [1:0] func_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	logic       advance, step;
	result_t    res;

	assign advance  = !out_valid_q || tx.ready;
	assign step     = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			func_s1 <= rx.func;
			byte_s1 <= rx.byte_in;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	hrhp_parse #(
		.METHOD_MAX (METHOD_MAX),
		.URL_MAX    (URL_MAX),
		.HEADER_MAX (HEADER_MAX)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.func    (func_s1),
		.byte_in (byte_s1),
		.res     (res)
	);

	assign tx.valid         = out_valid_q;
	assign tx.status        = res.status;
	assign tx.response_code = res.response_code;
	assign tx.dest          = res.dest;
	assign tx.dest_index    = res.dest_index;
	assign tx.byte_out      = res.byte_out;

	// a result word waiting on a stalled receiver must not be overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !tx.ready |=> out_valid_q && $stable(res))
		else $error("stalled result word changed");

	// the input stage is only refilled when it empties or advances
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !rx.ready)
		else $error("input stage overwritten while held");

	// every evaluated word produces a valid result word
	assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("evaluated word lost");

endmodule

[src/hrhp_parse.sv]
// parse state machine: phase, field and header row counters and the result register
module hrhp_parse #(
	parameter int METHOD_MAX = 10,
	parameter int URL_MAX    = 64,
	parameter int HEADER_MAX = 512
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [1:0]      func,
	input  logic [7:0]      byte_in,
	output hrhp_pkg::result_t res
);
	import hrhp_pkg::*;

	localparam int HC_W = $clog2(HEADER_MAX + 1);
	localparam int FC_MAX = (URL_MAX > METHOD_MAX) ? URL_MAX : METHOD_MAX;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_START   = 4'd1,
		PH_METHOD  = 4'd2,
		PH_URL     = 4'd3,
		PH_VERSION = 4'd4,
		PH_LF      = 4'd5,
		PH_CR      = 4'd6,
		PH_CRLF    = 4'd7,
		PH_CRLFCR  = 4'd8,
		PH_ROW     = 4'd9,
		PH_DONE    = 4'd10
	} phase_t;

	phase_t            phase_q, phase_d, put_ph;
	logic [7:0]        fc_q, fc_d;
	logic [HC_W-1:0]   hc_q, hc_d;
	result_t           res_q, res_d;
	logic              do_put, head_end, is_cr, is_lf, is_eol, is_upper;
	logic [HC_W+9:0]   hc_ext;

	assign is_cr    = (byte_in == CH_CR);
	assign is_lf    = (byte_in == CH_LF);
	assign is_eol   = is_cr || is_lf;
	assign is_upper = (byte_in >= CH_UPPER_A) && (byte_in <= CH_UPPER_Z);
	assign hc_ext   = {10'd0, hc_q};

	// next state and result for one word
	always_comb begin
		phase_d  = phase_q;
		fc_d     = fc_q;
		hc_d     = hc_q;
		res_d    = '0;
		res_d.status = ST_IDLE;
		do_put   = 1'b0;
		head_end = 1'b0;
		put_ph   = PH_ROW;

		case (func)
			FN_DATA: begin
				unique case (phase_q)
					PH_IDLE: begin
						res_d.status = ST_IDLE;
					end
					PH_DONE: begin
						res_d.status = ST_PAST;
					end
					PH_START, PH_METHOD: begin
						// method text, counter restarts on the first byte
						if (byte_in == CH_SPACE) begin
							res_d.status     = ST_CONSUMED;
							res_d.dest       = DST_METHOD;
							res_d.dest_index = (phase_q == PH_START) ? 10'd0 : {2'b00, fc_q};
							phase_d          = PH_URL;
							fc_d             = '0;
						end else if (!is_upper) begin
							res_d.status        = ST_SYNTAX;
							res_d.response_code = RC_BAD_REQUEST;
							phase_d             = PH_START;
							fc_d                = '0;
						end else if (phase_q == PH_METHOD && fc_q >= 8'(METHOD_MAX)) begin
							res_d.status        = ST_LONG;
							res_d.response_code = RC_HDR_LARGE;
							phase_d             = PH_START;
						end else begin
							res_d.status     = ST_STORED;
							res_d.dest       = DST_METHOD;
							res_d.dest_index = (phase_q == PH_START) ? 10'd0 : {2'b00, fc_q};
							res_d.byte_out   = byte_in;
							phase_d          = PH_METHOD;
							fc_d             = (phase_q == PH_START) ? 8'd1 : fc_q + 8'd1;
						end
					end
					PH_URL: begin
						if (byte_in == CH_SPACE) begin
							res_d.status = ST_CONSUMED;
							phase_d      = PH_VERSION;
						end else if (fc_q >= 8'(URL_MAX)) begin
							res_d.status        = ST_URI;
							res_d.response_code = RC_URI_LONG;
							phase_d             = PH_START;
						end else begin
							res_d.status     = ST_STORED;
							res_d.dest       = DST_URL;
							res_d.dest_index = {2'b00, fc_q};
							res_d.byte_out   = byte_in;
							fc_d             = fc_q + 8'd1;
						end
					end
					PH_VERSION: begin
						// version text skipped up to the first line end
						res_d.status = ST_CONSUMED;
						if (is_eol) begin
							hc_d    = '0;
							phase_d = is_cr ? PH_CR : PH_LF;
						end
					end
					PH_CR: begin
						if (is_lf) begin
							do_put = 1'b1;
							put_ph = PH_CRLF;
						end else if (is_cr) begin
							head_end = 1'b1;
						end else begin
							do_put = 1'b1;
						end
					end
					PH_LF, PH_CRLFCR: begin
						if (is_lf) head_end = 1'b1;
						else do_put = 1'b1;
					end
					PH_CRLF: begin
						if (is_cr) begin
							res_d.status = ST_CONSUMED;
							phase_d      = PH_CRLFCR;
						end else begin
							do_put = 1'b1;
						end
					end
					PH_ROW: begin
						do_put = 1'b1;
					end
					default: begin
						res_d.status        = ST_SYNTAX;
						res_d.response_code = RC_BAD_REQUEST;
						phase_d             = PH_START;
					end
				endcase

				// plain header row byte picks its line end phase
				if (do_put && put_ph == PH_ROW) begin
					if (is_cr) put_ph = PH_CR;
					else if (is_lf) put_ph = PH_LF;
				end

				// header row store
				if (do_put) begin
					phase_d = put_ph;
					if (is_eol && hc_q == '0) begin
						res_d.status = ST_CONSUMED;
					end else if (hc_q >= HC_W'(HEADER_MAX)) begin
						res_d.status        = ST_LONG;
						res_d.response_code = RC_HDR_LARGE;
						phase_d             = PH_START;
					end else begin
						res_d.status     = ST_STORED;
						res_d.dest       = DST_HEADER;
						res_d.dest_index = hc_ext[9:0];
						res_d.byte_out   = byte_in;
						hc_d             = hc_q + HC_W'(1);
					end
				end

				// blank line closes the head
				if (head_end) begin
					phase_d          = PH_DONE;
					res_d.status     = ST_COMPLETE;
					res_d.dest       = DST_HEADER;
					res_d.dest_index = hc_ext[9:0];
				end
			end
			FN_OPEN: begin
				if (phase_q != PH_IDLE) begin
					res_d.status = ST_REFUSED;
				end else begin
					res_d.status = ST_STARTED;
					phase_d      = PH_START;
				end
			end
			FN_CLOSE: begin
				res_d.status = ST_RELEASED;
				phase_d      = PH_IDLE;
			end
			default: begin
				res_d.status = ST_IDLE;
			end
		endcase
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fc_q    <= '0;
			hc_q    <= '0;
			res_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			fc_q    <= fc_d;
			hc_q    <= hc_d;
			res_q   <= res_d;
		end
	end

	assign res = res_q;

	// an error word always leaves the parser waiting for a new request line
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(step) && (res_q.status == ST_SYNTAX || res_q.status == ST_LONG ||
		res_q.status == ST_URI) |-> phase_q == PH_START)
		else $error("error word without return to request start");

	// header row counter never passes its limit
	assert property (@(posedge clk) disable iff (!arst_n)
		hc_q <= HC_W'(HEADER_MAX))
		else $error("header row counter overrun");

	// method and url counter stays within the longer field
	assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= 8'(FC_MAX))
		else $error("field counter overrun");

	// a completed head is followed by the done phase
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(step) && res_q.status == ST_COMPLETE |-> phase_q == PH_DONE)
		else $error("head complete without done phase");

endmodule

[bench/hrhp_result_checker.sv]
// result checker for the http request header parser: predicts every result word and compares
`timescale 1ns / 1ps

module hrhp_result_checker #(
	parameter int METHOD_MAX = 10,
	parameter int URL_MAX    = 64,
	parameter int HEADER_MAX = 512
) (
	input  logic clk,
	input  logic arst_n,
	hrhp_in_if   rx,
	hrhp_out_if  tx,
	output int   errors,
	output int   pending
);
	import hrhp_pkg::*;

	// where the parser stands within a request
	typedef enum logic [3:0] {
		P_NONE     = 4'd0,
		P_START    = 4'd1,
		P_METHOD   = 4'd2,
		P_URL      = 4'd3,
		P_VERSION  = 4'd4,
		P_LF       = 4'd5,
		P_CR       = 4'd6,
		P_CRLF     = 4'd7,
		P_CRLFCR   = 4'd8,
		P_ROW      = 4'd9,
		P_DONE     = 4'd10
	} phase_e;

	phase_e      phase;
	logic [7:0]  field_cnt;
	logic [15:0] row_cnt;
	result_t     awaited[$];

	function automatic result_t make_word(logic [3:0] st, logic [8:0] code, logic [1:0] dst,
		logic [9:0] idx, logic [7:0] b);
		result_t w;
		w.status        = st;
		w.response_code = code;
		w.dest          = dst;
		w.dest_index    = idx;
		w.byte_out      = b;
		return w;
	endfunction

	// error words drop the parser back to the request start
	function automatic result_t reject(logic [3:0] st, logic [8:0] code);
		phase = P_START;
		return make_word(st, code, DST_NONE, '0, '0);
	endfunction

	// one header row byte; line ends before any row byte are swallowed
	function automatic result_t store_row(logic [7:0] ch);
		result_t w;
		if ((ch == CH_LF || ch == CH_CR) && row_cnt == 0) begin
			w = make_word(ST_CONSUMED, RC_NONE, DST_NONE, '0, '0);
		end else if (row_cnt >= HEADER_MAX) begin
			w = reject(ST_LONG, RC_HDR_LARGE);
		end else begin
			w = make_word(ST_STORED, RC_NONE, DST_HEADER, row_cnt[9:0], ch);
			row_cnt++;
		end
		return w;
	endfunction

	function automatic result_t head_complete();
		phase = P_DONE;
		return make_word(ST_COMPLETE, RC_NONE, DST_HEADER, row_cnt[9:0], '0);
	endfunction

	// header rows: track lf, cr and crlf endings to spot the blank line
	function automatic result_t row_byte(logic [7:0] ch);
		phase_e p;
		p = phase;
		if (p == P_CR) begin
			if (ch == CH_LF) begin
				phase = P_CRLF;
				return store_row(ch);
			end
			if (ch == CH_CR)
				return head_complete();
			p = P_ROW;
		end
		if (p == P_LF || p == P_CRLFCR) begin
			if (ch == CH_LF)
				return head_complete();
			p = P_ROW;
		end
		if (p == P_CRLF) begin
			if (ch == CH_CR) begin
				phase = P_CRLFCR;
				return make_word(ST_CONSUMED, RC_NONE, DST_NONE, '0, '0);
			end
			p = P_ROW;
		end
		if (ch == CH_CR)
			p = P_CR;
		else if (ch == CH_LF)
			p = P_LF;
		phase = p;
		return store_row(ch);
	endfunction

	function automatic result_t data_byte(logic [7:0] ch);
		result_t w;
		if (phase == P_NONE)
			return make_word(ST_IDLE, RC_NONE, DST_NONE, '0, '0);
		if (phase == P_DONE)
			return make_word(ST_PAST, RC_NONE, DST_NONE, '0, '0);
		if (phase == P_START) begin
			phase     = P_METHOD;
			field_cnt = '0;
		end
		case (phase)
			P_METHOD: begin
				if (ch == CH_SPACE) begin
					w         = make_word(ST_CONSUMED, RC_NONE, DST_METHOD, {2'b00, field_cnt}, '0);
					phase     = P_URL;
					field_cnt = '0;
				end else if (ch < CH_UPPER_A || ch > CH_UPPER_Z) begin
					w = reject(ST_SYNTAX, RC_BAD_REQUEST);
				end else if (field_cnt >= METHOD_MAX) begin
					w = reject(ST_LONG, RC_HDR_LARGE);
				end else begin
					w = make_word(ST_STORED, RC_NONE, DST_METHOD, {2'b00, field_cnt}, ch);
					field_cnt++;
				end
			end
			P_URL: begin
				if (ch == CH_SPACE) begin
					phase = P_VERSION;
					w     = make_word(ST_CONSUMED, RC_NONE, DST_NONE, '0, '0);
				end else if (field_cnt >= URL_MAX) begin
					w = reject(ST_URI, RC_URI_LONG);
				end else begin
					w = make_word(ST_STORED, RC_NONE, DST_URL, {2'b00, field_cnt}, ch);
					field_cnt++;
				end
			end
			P_VERSION: begin
				// version text is skipped up to the first line end
				if (ch == CH_CR || ch == CH_LF) begin
					row_cnt = '0;
					phase   = (ch == CH_CR) ? P_CR : P_LF;
				end
				w = make_word(ST_CONSUMED, RC_NONE, DST_NONE, '0, '0);
			end
			P_LF, P_CR, P_CRLF, P_CRLFCR, P_ROW: begin
				w = row_byte(ch);
			end
			default: begin
				w = reject(ST_SYNTAX, RC_BAD_REQUEST);
			end
		endcase
		return w;
	endfunction

	// expected result of one request word
	function automatic result_t parse_step(logic [1:0] fn, logic [7:0] ch);
		result_t w;
		case (fn)
			FN_DATA: begin
				w = data_byte(ch);
			end
			FN_OPEN: begin
				if (phase != P_NONE) begin
					w = make_word(ST_REFUSED, RC_NONE, DST_NONE, '0, '0);
				end else begin
					phase = P_START;
					w     = make_word(ST_STARTED, RC_NONE, DST_NONE, '0, '0);
				end
			end
			FN_CLOSE: begin
				phase = P_NONE;
				w     = make_word(ST_RELEASED, RC_NONE, DST_NONE, '0, '0);
			end
			default: begin
				w = make_word(ST_IDLE, RC_NONE, DST_NONE, '0, '0);
			end
		endcase
		return w;
	endfunction

	function automatic int field_differs(string name, int want, int got);
		if (want == got)
			return 0;
		$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		return 1;
	endfunction

	// compare result words in order, predict each accepted request word
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		int      bad;
		if (!arst_n) begin
			phase     = P_NONE;
			field_cnt = '0;
			row_cnt   = '0;
			awaited.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			bad = 0;
			if (tx.valid && tx.ready) begin
				if (awaited.size() == 0) begin
					$display("%0t: no word expected, got status %0d code %0d dest %0d index %0d byte %0d",
						$time, tx.status, tx.response_code, tx.dest, tx.dest_index, tx.byte_out);
					bad = 1;
				end else begin
					want = awaited.pop_front();
					bad += field_differs("status", want.status, tx.status);
					bad += field_differs("response_code", want.response_code, tx.response_code);
					bad += field_differs("dest", want.dest, tx.dest);
					bad += field_differs("dest_index", want.dest_index, tx.dest_index);
					bad += field_differs("byte_out", want.byte_out, tx.byte_out);
				end
			end
			if (rx.valid && rx.ready)
				awaited.push_back(parse_step(rx.func, rx.byte_in));
			errors  <= errors + bad;
			pending <= awaited.size();
		end
	end

endmodule

[bench/tb_http_request_header_parser.sv]
// testbench top for the http request header parser: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module tb_http_request_header_parser;
	import hrhp_pkg::*;

	localparam int METHOD_MAX = 10;
	localparam int URL_MAX    = 64;
	localparam int HEADER_MAX = 512;

	localparam int CLK_PERIOD = 10;
	localparam int ITEMS      = 1900;
	localparam int LONG_HOLD  = 200;
	localparam int DRAIN      = 20;
	localparam int STALL_LIMIT = 4000;

	// function code the block does not define
	localparam logic [1:0] FN_UNUSED = 2'd3;

	// line ending styles
	localparam int EOL_LF   = 0;
	localparam int EOL_CR   = 1;
	localparam int EOL_CRLF = 2;

	typedef enum int {
		REQ_PLAIN,
		REQ_BAD_METHOD,
		REQ_LONG_METHOD,
		REQ_LONG_URL,
		REQ_LONG_ROW
	} req_e;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   awaited_count;
	int   words_sent;
	int   idle_cycles;
	bit   hold_long;
	int   send_run;
	bit   send_calm;
	int   take_run;
	bit   take_calm;

	hrhp_in_if  rx_if ();
	hrhp_out_if tx_if ();

	http_request_header_parser #(
		.METHOD_MAX (METHOD_MAX),
		.URL_MAX    (URL_MAX),
		.HEADER_MAX (HEADER_MAX)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if)
	);

	hrhp_result_checker #(
		.METHOD_MAX (METHOD_MAX),
		.URL_MAX    (URL_MAX),
		.HEADER_MAX (HEADER_MAX)
	) i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_if),
		.tx      (tx_if),
		.errors  (fail_count),
		.pending (awaited_count)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// no word moving on either side for too long ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// one request word, after a random gap; calm stretches have no gaps
	task automatic send_word(logic [1:0] fn, logic [7:0] b);
		int gap;
		if (send_run == 0) begin
			send_calm = ($urandom_range(0, 3) == 0);
			send_run  = $urandom_range(20, 80);
		end
		send_run--;
		gap = send_calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.func    <= fn;
		rx_if.byte_in <= b;
		do
			@(posedge clk);
		while (!rx_if.ready);
		words_sent++;
	endtask

	function automatic logic [7:0] byte_except(logic [7:0] a, logic [7:0] b);
		logic [7:0] ch;
		do
			ch = 8'($urandom_range(0, 255));
		while (ch == a || ch == b);
		return ch;
	endfunction

	task automatic send_eol(int style);
		if (style == EOL_LF) begin
			send_word(FN_DATA, CH_LF);
		end else begin
			send_word(FN_DATA, CH_CR);
			if (style == EOL_CRLF)
				send_word(FN_DATA, CH_LF);
		end
	endtask

	// open, method, url, version, header rows, blank line, close
	task automatic send_request(req_e mode);
		int         mlen;
		int         ulen;
		int         nrows;
		int         rlen;
		int         eol;
		int         bad_at;
		logic [7:0] ch;
		send_word(FN_OPEN, 8'($urandom_range(0, 255)));
		case (mode)
			REQ_LONG_METHOD: mlen = $urandom_range(METHOD_MAX + 1, METHOD_MAX + 3);
			REQ_BAD_METHOD:  mlen = $urandom_range(1, METHOD_MAX);
			default:         mlen = $urandom_range(0, METHOD_MAX);
		endcase
		bad_at = (mode == REQ_BAD_METHOD) ? $urandom_range(0, mlen - 1) : -1;
		for (int i = 0; i < mlen; i++) begin
			if (i == bad_at) begin
				do
					ch = 8'($urandom_range(0, 255));
				while ((ch >= CH_UPPER_A && ch <= CH_UPPER_Z) || ch == CH_SPACE);
			end else begin
				ch = CH_UPPER_A + 8'($urandom_range(0, 25));
			end
			send_word(FN_DATA, ch);
		end
		send_word(FN_DATA, CH_SPACE);
		if (mode == REQ_LONG_URL)
			ulen = $urandom_range(URL_MAX + 1, URL_MAX + 4);
		else if ($urandom_range(0, 7) == 0)
			ulen = URL_MAX;
		else
			ulen = $urandom_range(0, 24);
		repeat (ulen) send_word(FN_DATA, byte_except(CH_SPACE, CH_SPACE));
		send_word(FN_DATA, CH_SPACE);
		// version text
		repeat ($urandom_range(0, 10)) send_word(FN_DATA, byte_except(CH_CR, CH_LF));
		eol = $urandom_range(EOL_LF, EOL_CRLF);
		send_eol(eol);
		nrows = (mode == REQ_LONG_ROW) ? 1 : $urandom_range(0, 4);
		repeat (nrows) begin
			rlen = (mode == REQ_LONG_ROW) ? HEADER_MAX + 2 : $urandom_range(1, 30);
			repeat (rlen) send_word(FN_DATA, byte_except(CH_CR, CH_LF));
			if ($urandom_range(0, 5) == 0)
				eol = $urandom_range(EOL_LF, EOL_CRLF);
			send_eol(eol);
		end
		// blank line, then a few bytes past the head
		send_eol(eol);
		repeat ($urandom_range(0, 2)) send_word(FN_DATA, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) == 0)
			send_word(FN_OPEN, 8'($urandom_range(0, 255)));
		send_word(FN_CLOSE, 8'($urandom_range(0, 255)));
	endtask

	// result side: random stalls, calm stretches and one long hold-off
	initial begin : take_results
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (take_run == 0) begin
				take_calm = ($urandom_range(0, 3) == 0);
				take_run  = $urandom_range(20, 80);
			end
			take_run--;
			stall = take_calm ? 0 : $urandom_range(0, 12);
			if (hold_long) begin
				hold_long = 1'b0;
				stall     = LONG_HOLD;
			end
			if (stall > 0) begin
				tx_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			tx_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (!tx_if.valid);
		end
	end

	// reset, directed words, random requests, drain and verdict
	initial begin : make_requests
		req_e mode;
		int   pick;
		int   k;
		rx_if.valid   = 1'b0;
		rx_if.func    = FN_DATA;
		rx_if.byte_in = 8'h00;
		tx_if.ready   = 1'b0;
		arst_n        = 1'b0;
		words_sent    = 0;
		idle_cycles   = 0;
		hold_long     = 1'b0;
		send_run      = 0;
		take_run      = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no request open, unused code, close while idle
		send_word(FN_DATA, CH_UPPER_A);
		send_word(FN_UNUSED, 8'hff);
		send_word(FN_CLOSE, 8'h00);
		// open twice, empty method and url, extreme url bytes, crlf blank line
		send_word(FN_OPEN, 8'h00);
		send_word(FN_OPEN, 8'hff);
		send_word(FN_DATA, CH_SPACE);
		send_word(FN_DATA, 8'h00);
		send_word(FN_DATA, 8'hff);
		send_word(FN_DATA, CH_SPACE);
		send_word(FN_DATA, CH_CR);
		send_word(FN_DATA, CH_LF);
		send_word(FN_DATA, CH_CR);
		send_word(FN_DATA, CH_LF);
		send_word(FN_DATA, CH_UPPER_Z);
		send_word(FN_CLOSE, 8'hff);
		// method letter limits and the characters just outside them
		send_word(FN_OPEN, 8'h55);
		send_word(FN_DATA, CH_UPPER_A);
		send_word(FN_DATA, CH_UPPER_Z);
		send_word(FN_DATA, CH_UPPER_A - 8'd1);
		send_word(FN_DATA, CH_UPPER_Z + 8'd1);
		send_word(FN_CLOSE, 8'haa);

		// random requests, every error kind forced early on
		k = 0;
		while (words_sent < ITEMS) begin
			case (k)
				0: mode = REQ_LONG_ROW;
				1: mode = REQ_LONG_URL;
				2: mode = REQ_LONG_METHOD;
				3: mode = REQ_BAD_METHOD;
				default: begin
					pick = $urandom_range(0, 99);
					if (pick < 5)
						mode = REQ_BAD_METHOD;
					else if (pick < 9)
						mode = REQ_LONG_METHOD;
					else if (pick < 12)
						mode = REQ_LONG_URL;
					else if (pick < 13)
						mode = REQ_LONG_ROW;
					else
						mode = REQ_PLAIN;
				end
			endcase
			if (k == 6)
				hold_long = 1'b1;
			if (k == 12) begin
				// let every outstanding result word come back first
				rx_if.valid <= 1'b0;
				@(posedge clk);
				wait (awaited_count == 0);
				@(posedge clk);
			end
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 4))
					send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			send_request(mode);
			k++;
		end

		rx_if.valid <= 1'b0;
		@(posedge clk);
		wait (awaited_count == 0);
		repeat (DRAIN) @(posedge clk);
		if (fail_count == 0 && awaited_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[filelist.f]
src/hrhp_pkg.sv
src/hrhp_if.sv
src/hrhp_parse.sv
src/http_request_header_parser.sv
bench/hrhp_result_checker.sv
bench/tb_http_request_header_parser.sv
